FILE: rtl/core/first_fit_segment_allocator_assert.svh
// ---------------------------------------------------------------------------
// first_fit_segment_allocator_assert: assertion macros
// Clocked, reset-gated property checks for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// check that a condition holds at every clock edge out of reset
`define FFSA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// check an implication into the next cycle
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ffsa_pkg.sv
// ---------------------------------------------------------------------------
// ffsa_pkg: shared definitions
// Constants, status codes, controller states and cell commands.
// ---------------------------------------------------------------------------
package ffsa_pkg;

	localparam int MaxSegments = 16;
	localparam int AddrBits    = 16;
	localparam int MemWordsRst = 256;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NOFREE  = 3'd1;
	localparam logic [2:0] STAT_NOFIT   = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_NOMATCH = 3'd4;
	localparam logic [2:0] STAT_ZERO    = 3'd5;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ASCAN,
		ST_FSCAN,
		ST_MERGE,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INIT,
		CELL_WRITE,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

endpackage

FILE: rtl/core/first_fit_segment_allocator.sv
// A zero or oversized request is answered directly; an allocate walks the table
// one entry a cycle until the first fit; a free walks all entries, then runs one
// merge step a cycle.
// Throughput: one request in work at a time; the next is taken in the cycle after the
// result moves into the output register, which holds the controller while it is full.
// Reset: table holds one free segment of 256 words; a write of mem_words sets one of the written size.
// ---------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit allocator with coalescing
// Segment table as a row of cells driven by a scanning controller.
// ---------------------------------------------------------------------------
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegments,
	parameter int ADDR_BITS    = ffsa_pkg::AddrBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // req_size[15:0], req_start[31:16]
	input  logic [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // status[2:0], seg_start_out[18:3],
	                               // seg_size_out[34:19], free_total[50:35], zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ffsa_pkg::*;

	localparam int N  = MAX_SEGMENTS;
	localparam int AB = ADDR_BITS;
	localparam int IW = $clog2(N);
	localparam int CW = IW + 1;
	localparam int W  = (AB > 16) ? AB : 16;

	state_t state_q, state_d;

	logic [AB-1:0] mem_q, free_q;
	logic [CW-1:0] cnt_q, ic_q, ic_nx;
	logic          func_q, found_q;
	logic [15:0]   size_q, start_q, ostart_q;
	logic [2:0]    st_q;
	logic          m_valid_q;
	logic [55:0]   m_data_q;

	logic [AB-1:0] c_start [N];
	logic [AB-1:0] c_len   [N];
	logic          c_used  [N];
	logic [AB-1:0] n_len   [N];
	logic          n_used  [N];

	cell_op_t      op;
	logic [AB-1:0] a_start, a_len, b_start, b_len;
	logic          a_used;

	logic [IW-1:0] idx;
	logic [AB-1:0] rd_start, rd_len, nb_len;
	logic          rd_used, nb_used;
	logic [W-1:0]  size_w, len_w, in_size_w;
	logic          accept, cfg_wr, load;
	logic          at_end, mrg_end, fit, exact, full, match, both_free;
	logic          in_zero, in_big;

	assign accept = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign load   = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	assign idx      = ic_q[IW-1:0];
	assign rd_start = c_start[idx];
	assign rd_len   = c_len[idx];
	assign rd_used  = c_used[idx];
	assign nb_len   = n_len[idx];
	assign nb_used  = n_used[idx];

	assign size_w    = W'(size_q);
	assign len_w     = W'(rd_len);
	assign in_size_w = W'(s_tdata[15:0]);
	assign ic_nx     = ic_q + CW'(1);

	assign at_end    = (ic_q >= cnt_q);
	assign mrg_end   = (ic_nx >= cnt_q);
	assign fit       = !rd_used && (len_w >= size_w);
	assign exact     = (len_w == size_w);
	assign full      = (cnt_q == CW'(N));
	assign match     = (W'(rd_start) == W'(start_q)) && (len_w == size_w);
	assign both_free = !rd_used && !nb_used;
	assign in_zero   = (s_tdata[15:0] == 16'd0);
	assign in_big    = (s_tuser[0] == FUNC_ALLOC) &&
	                   ((in_size_w > W'(mem_q)) || (in_size_w > W'(free_q)));

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			logic [AB-1:0] l_start, l_len, r_start, r_len;
			logic          l_used, r_used;
			if (k == 0) begin : g_lo
				assign l_start = c_start[k];
				assign l_len   = c_len[k];
				assign l_used  = c_used[k];
			end else begin : g_li
				assign l_start = c_start[k-1];
				assign l_len   = c_len[k-1];
				assign l_used  = c_used[k-1];
			end
			if (k == N - 1) begin : g_ro
				assign r_start = c_start[k];
				assign r_len   = c_len[k];
				assign r_used  = 1'b1;
			end else begin : g_ri
				assign r_start = c_start[k+1];
				assign r_len   = c_len[k+1];
				assign r_used  = c_used[k+1];
			end
			assign n_len[k]  = r_len;
			assign n_used[k] = r_used;

			ffsa_cell #(.IDX(k), .AB(AB), .IW(IW)) u_cell (
				.clk(clk), .arst_n(arst_n), .op(op), .sel(idx),
				.a_start(a_start), .a_len(a_len), .a_used(a_used),
				.b_start(b_start), .b_len(b_len), .init_len(AB'(pwdata[15:0])),
				.left_start(l_start), .left_len(l_len), .left_used(l_used),
				.right_start(r_start), .right_len(r_len), .right_used(r_used),
				.start(c_start[k]), .len(c_len[k]), .used(c_used[k])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_zero || in_big)
						state_d = ST_DONE;
					else if (s_tuser[0] == FUNC_FREE)
						state_d = ST_FSCAN;
					else
						state_d = ST_ASCAN;
				end
			end
			ST_ASCAN: begin
				if (at_end || fit)
					state_d = ST_DONE;
			end
			ST_FSCAN: begin
				if (at_end)
					state_d = found_q ? ST_MERGE : ST_DONE;
			end
			ST_MERGE: begin
				if (mrg_end)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op      = CELL_HOLD;
		a_start = rd_start;
		a_len   = rd_len;
		a_used  = 1'b0;
		b_start = rd_start + AB'(size_w);
		b_len   = rd_len - AB'(size_w);
		case (state_q)
			ST_IDLE: begin
				if (cfg_wr)
					op = CELL_INIT;
			end
			ST_ASCAN: begin
				if (!at_end && fit) begin
					a_used = 1'b1;
					if (exact) begin
						op = CELL_WRITE;
					end else if (!full) begin
						op    = CELL_INSERT;
						a_len = AB'(size_w);
					end
				end
			end
			ST_FSCAN: begin
				if (!at_end && match)
					op = CELL_WRITE;
			end
			ST_MERGE: begin
				if (!mrg_end && both_free) begin
					op    = CELL_REMOVE;
					a_len = rd_len + nb_len;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mem_q     <= AB'(MemWordsRst);
			free_q    <= AB'(MemWordsRst);
			cnt_q     <= CW'(1);
			ic_q      <= '0;
			found_q   <= 1'b0;
			func_q    <= FUNC_ALLOC;
			size_q    <= '0;
			start_q   <= '0;
			ostart_q  <= '0;
			st_q      <= STAT_OK;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						mem_q  <= AB'(pwdata[15:0]);
						free_q <= AB'(pwdata[15:0]);
						cnt_q  <= CW'(1);
					end
					if (accept) begin
						func_q   <= s_tuser[0];
						size_q   <= s_tdata[15:0];
						start_q  <= s_tdata[31:16];
						ic_q     <= '0;
						found_q  <= 1'b0;
						ostart_q <= '0;
						st_q     <= in_zero ? STAT_ZERO : (in_big ? STAT_NOFREE : STAT_OK);
					end
				end
				ST_ASCAN: begin
					if (at_end) begin
						st_q <= STAT_NOFIT;
					end else if (fit) begin
						if (exact) begin
							ostart_q <= 16'(W'(rd_start));
							free_q   <= free_q - AB'(size_w);
						end else if (full) begin
							st_q <= STAT_FULL;
						end else begin
							ostart_q <= 16'(W'(rd_start));
							free_q   <= free_q - AB'(size_w);
							cnt_q    <= cnt_q + CW'(1);
						end
					end else begin
						ic_q <= ic_nx;
					end
				end
				ST_FSCAN: begin
					if (!at_end) begin
						if (match) begin
							found_q <= 1'b1;
							if (rd_used)
								free_q <= free_q + rd_len;
						end
						ic_q <= ic_nx;
					end else begin
						if (!found_q)
							st_q <= STAT_NOMATCH;
						ic_q <= '0;
					end
				end
				ST_MERGE: begin
					if (!mrg_end) begin
						if (both_free)
							cnt_q <= cnt_q - CW'(1);
						else
							ic_q <= ic_nx;
					end
				end
				ST_DONE: begin
					if (load) begin
						m_data_q  <= {5'd0, 16'(W'(free_q)),
						              (st_q == STAT_OK) ? size_q : 16'd0,
						              (st_q == STAT_OK && func_q == FUNC_ALLOC) ? ostart_q : 16'd0,
						              st_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? 32'(mem_q) : 32'd0;

	`include "first_fit_segment_allocator_assert.svh"

	`FFSA_ASSERT_ALWAYS(a_cnt_range, (cnt_q >= CW'(1)) && (cnt_q <= CW'(N)), "segment count out of range")
	`FFSA_ASSERT_ALWAYS(a_free_le_mem, W'(free_q) <= W'(mem_q), "free total above memory size")
	`FFSA_ASSERT_NEXT(a_busy_after_req, accept, !s_tready, "request taken while busy")

endmodule

FILE: rtl/core/ffsa_cell.sv
// ---------------------------------------------------------------------------
// ffsa_cell: one segment table entry
// Holds start, length and used mark; shifts from its neighbours on insert
// and remove, takes direct writes when selected.
// ---------------------------------------------------------------------------
module ffsa_cell #(
	parameter int IDX = 0,
	parameter int AB  = 16,
	parameter int IW  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffsa_pkg::cell_op_t op,
	input  logic [IW-1:0]     sel,
	input  logic [AB-1:0]     a_start,
	input  logic [AB-1:0]     a_len,
	input  logic              a_used,
	input  logic [AB-1:0]     b_start,
	input  logic [AB-1:0]     b_len,
	input  logic [AB-1:0]     init_len,
	input  logic [AB-1:0]     left_start,
	input  logic [AB-1:0]     left_len,
	input  logic              left_used,
	input  logic [AB-1:0]     right_start,
	input  logic [AB-1:0]     right_len,
	input  logic              right_used,
	output logic [AB-1:0]     start,
	output logic [AB-1:0]     len,
	output logic              used
);
	import ffsa_pkg::*;

	logic [AB-1:0] start_q;
	logic [AB-1:0] len_q;
	logic          used_q;
	int            s;

	assign s = int'(sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= (IDX == 0) ? AB'(MemWordsRst) : '0;
			used_q  <= 1'b0;
		end else begin
			case (op)
				CELL_INIT: begin
					start_q <= '0;
					len_q   <= (IDX == 0) ? init_len : '0;
					used_q  <= 1'b0;
				end
				CELL_WRITE: begin
					if (IDX == s) begin
						start_q <= a_start;
						len_q   <= a_len;
						used_q  <= a_used;
					end
				end
				CELL_INSERT: begin
					if (IDX == s) begin
						start_q <= a_start;
						len_q   <= a_len;
						used_q  <= a_used;
					end else if (IDX == s + 1) begin
						start_q <= b_start;
						len_q   <= b_len;
						used_q  <= 1'b0;
					end else if (IDX > s + 1) begin
						start_q <= left_start;
						len_q   <= left_len;
						used_q  <= left_used;
					end
				end
				CELL_REMOVE: begin
					if (IDX == s) begin
						start_q <= a_start;
						len_q   <= a_len;
						used_q  <= a_used;
					end else if (IDX > s) begin
						start_q <= right_start;
						len_q   <= right_len;
						used_q  <= right_used;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign start = start_q;
	assign len   = len_q;
	assign used  = used_q;

endmodule
